/* rtl/tcce_pkg.sv */
// Package for the text console cell engine: grid geometry, field widths,
// character codes and the sequencer state type. No dependencies.
package tcce_pkg;

    localparam int TEXT_ROWS = 48;
    localparam int TEXT_COLS = 128;
    localparam int CELLS     = TEXT_ROWS * TEXT_COLS;

    localparam int CELL_AW = $clog2(CELLS);
    localparam int ROW_AW  = $clog2(TEXT_ROWS);
    localparam int COL_AW  = $clog2(TEXT_COLS);
    localparam int CNT_W   = $clog2(CELLS + TEXT_COLS + 1);

    localparam int CHAR_W    = 8;
    localparam int SCALE_W   = 3;
    localparam int POS_W     = 16;
    localparam int PIX_W     = 13;
    localparam int OROW_W    = 6;
    localparam int OCOL_W    = 7;
    localparam int OCURCOL_W = 8;
    localparam int CELL_W    = CHAR_W + SCALE_W;

    localparam int ROW_HEIGHT_SH = 4;
    localparam int GLYPH_W_SH    = 3;

    localparam logic [CHAR_W-1:0]  CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0]  CH_RETURN  = 8'd13;
    localparam logic [CHAR_W-1:0]  CH_SPACE   = 8'd32;
    localparam logic [SCALE_W-1:0] SCALE_ONE  = 3'd1;
    localparam logic [CELL_W-1:0]  CELL_FILL  = {CH_SPACE, SCALE_ONE};

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_SHIFT,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

/* rtl/tcce_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package dependencies.
module tcce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/text_console_cell_engine.sv */
// Text console cell engine: carriage return or a glyph without wrap runs EXEC then
// DONE; newline or wrap adds a row-height scan (SCAN), and a scroll adds a grid shift
// (SHIFT) before that scan, both paced by the single cell memory port. A new item is
// taken only in IDLE, so not before the last one has given its result.
// After reset the cell memory is cleared one cell a cycle with busy high; the result
// strobe cannot be stalled. Uses tcce_pkg and tcce_ram.
module text_console_cell_engine (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [tcce_pkg::CHAR_W-1:0]  i_char_code,
    input  logic                         i_cfg_we,
    input  logic [tcce_pkg::SCALE_W-1:0] i_cfg_wdata,
    output logic                         o_done,
    output logic                         o_draw_valid,
    output logic [tcce_pkg::OROW_W-1:0]  o_cell_row,
    output logic [tcce_pkg::OCOL_W-1:0]  o_cell_col,
    output logic [tcce_pkg::CHAR_W-1:0]  o_glyph_code,
    output logic [tcce_pkg::SCALE_W-1:0] o_glyph_scale,
    output logic [tcce_pkg::PIX_W-1:0]   o_pixel_x,
    output logic [tcce_pkg::PIX_W-1:0]   o_pixel_y,
    output logic                         o_scrolled,
    output logic [tcce_pkg::OROW_W-1:0]  o_cursor_row_out,
    output logic [tcce_pkg::OCURCOL_W-1:0] o_cursor_col_out
);
    import tcce_pkg::*;

    t_state r_state, n_state;

    logic [SCALE_W-1:0] r_scale;
    logic [ROW_AW-1:0]  r_cur_row;
    logic [COL_AW-1:0]  r_cur_col;
    logic [CHAR_W-1:0]  r_char;
    logic               r_pos_valid;
    logic [CNT_W-1:0]   r_cnt;

    // Row-height scan counters and the read pipeline behind them.
    logic [ROW_AW-1:0]  r_row_c;
    logic [COL_AW-1:0]  r_col_c;
    logic               r_sv;
    logic               r_slast;
    logic [ROW_AW-1:0]  r_srow;
    logic [SCALE_W-1:0] r_max;
    logic [POS_W-1:0]   r_acc;

    // Delayed write of the grid shift.
    logic               r_wen;
    logic [CELL_AW-1:0] r_wa;
    logic               r_wfill;

    logic               c_we;
    logic [CELL_AW-1:0] c_waddr, c_raddr;
    logic [CELL_W-1:0]  c_wdata, c_rdata;
    logic               p_we;
    logic [ROW_AW-1:0]  p_waddr;
    logic [POS_W-1:0]   p_wdata, p_rdata;

    logic                      is_nl, is_cr, is_gl, wrap, row_adv, do_scroll;
    logic [COL_AW:0]           col_inc;
    logic [ROW_AW:0]           row_inc;
    logic [ROW_AW-1:0]         new_row;
    logic [COL_AW-1:0]         new_col;
    logic [CELL_AW-1:0]        cur_addr;
    logic [COL_AW+SCALE_W-1:0] px_prod;
    logic [PIX_W-1:0]          px, py;
    logic [CNT_W-1:0]          shift_rd;
    logic                      scan_issue, scan_end, clear_end, shift_end;
    logic [SCALE_W-1:0]        d_scale, m_cur;
    logic [POS_W-1:0]          acc_n;

    // Decode of the item being executed.
    always_comb begin
        is_nl     = (r_char == CH_NEWLINE);
        is_cr     = (r_char == CH_RETURN);
        is_gl     = !is_nl && !is_cr;
        col_inc   = {1'b0, r_cur_col} + (COL_AW+1)'(1);
        wrap      = is_gl && (col_inc >= (COL_AW+1)'(TEXT_COLS));
        row_adv   = is_nl || wrap;
        row_inc   = {1'b0, r_cur_row} + (ROW_AW+1)'(1);
        do_scroll = row_adv && (row_inc == (ROW_AW+1)'(TEXT_ROWS));
        if (do_scroll) begin
            new_row = ROW_AW'(TEXT_ROWS - 1);
        end else if (row_adv) begin
            new_row = row_inc[ROW_AW-1:0];
        end else begin
            new_row = r_cur_row;
        end
        new_col  = (is_nl || is_cr || wrap) ? COL_AW'(1) : col_inc[COL_AW-1:0];
        cur_addr = CELL_AW'(CELL_AW'(r_cur_row) * CELL_AW'(TEXT_COLS))
                 + CELL_AW'(r_cur_col);
        px_prod  = (COL_AW+SCALE_W)'(r_cur_col) * (COL_AW+SCALE_W)'(r_scale);
        px       = PIX_W'({px_prod, {GLYPH_W_SH{1'b0}}});
        // Row 0 always sits at pixel 0; before the first scan every row does.
        py       = (r_pos_valid && r_cur_row != '0) ? PIX_W'(p_rdata) : '0;
    end

    // Sequencing conditions and the shared max/accumulate unit.
    always_comb begin
        shift_rd   = r_cnt + CNT_W'(TEXT_COLS);
        clear_end  = (r_cnt == CNT_W'(CELLS - 1));
        shift_end  = (r_cnt == CNT_W'(CELLS - 1));
        scan_issue = (r_row_c != ROW_AW'(TEXT_ROWS - 1));
        scan_end   = r_sv && r_slast && (r_srow == ROW_AW'(TEXT_ROWS - 2));
        d_scale    = c_rdata[SCALE_W-1:0];
        m_cur      = (d_scale > r_max) ? d_scale : r_max;
        acc_n      = r_acc + POS_W'({m_cur, {ROW_HEIGHT_SH{1'b0}}});
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clear_end) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (do_scroll) begin
                    n_state = S_SHIFT;
                end else if (row_adv) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SHIFT: begin
                if (shift_end) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (scan_end) n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State-decoded outputs.
    always_comb begin
        busy   = 1'b1;
        o_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                busy = 1'b0;
            end
            S_DONE: begin
                o_done = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // Memory port selection.
    always_comb begin
        c_we    = 1'b0;
        c_waddr = r_wa;
        c_wdata = r_wfill ? CELL_FILL : c_rdata;
        if (r_state == S_CLEAR) begin
            c_we    = 1'b1;
            c_waddr = r_cnt[CELL_AW-1:0];
            c_wdata = CELL_FILL;
        end else if (r_wen) begin
            c_we = 1'b1;
        end else if (r_state == S_EXEC && is_gl) begin
            c_we    = 1'b1;
            c_waddr = cur_addr;
            c_wdata = {r_char, r_scale};
        end
        c_raddr = (r_state == S_SHIFT) ? shift_rd[CELL_AW-1:0] : r_cnt[CELL_AW-1:0];

        p_we    = (r_state == S_SCAN) && r_sv && r_slast;
        p_waddr = r_srow + ROW_AW'(1);
        p_wdata = acc_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_scale     <= SCALE_ONE;
            r_cur_row   <= '0;
            r_cur_col   <= COL_AW'(1);
            r_pos_valid <= 1'b0;
            r_cnt       <= '0;
            r_wen       <= 1'b0;
            r_sv        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_scale <= i_cfg_wdata;
            end
            r_wen <= 1'b0;
            r_sv  <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_cnt <= clear_end ? '0 : r_cnt + CNT_W'(1);
                end
                S_IDLE: begin
                    if (start) r_char <= i_char_code;
                end
                S_EXEC: begin
                    r_cur_row        <= new_row;
                    r_cur_col        <= new_col;
                    r_cnt            <= '0;
                    r_row_c          <= '0;
                    r_col_c          <= '0;
                    r_max            <= SCALE_ONE;
                    r_acc            <= '0;
                    o_draw_valid     <= is_gl;
                    o_cell_row       <= is_gl ? OROW_W'(r_cur_row) : '0;
                    o_cell_col       <= is_gl ? OCOL_W'(r_cur_col) : '0;
                    o_glyph_code     <= is_gl ? r_char : '0;
                    o_glyph_scale    <= is_gl ? r_scale : '0;
                    o_pixel_x        <= is_gl ? px : '0;
                    o_pixel_y        <= is_gl ? py : '0;
                    o_scrolled       <= do_scroll;
                    o_cursor_row_out <= OROW_W'(new_row);
                    o_cursor_col_out <= OCURCOL_W'(new_col);
                end
                S_SHIFT: begin
                    // Cell k takes the cell one row below; the last row fills with spaces.
                    r_wen   <= 1'b1;
                    r_wa    <= r_cnt[CELL_AW-1:0];
                    r_wfill <= (shift_rd >= CNT_W'(CELLS));
                    r_cnt   <= shift_end ? '0 : r_cnt + CNT_W'(1);
                end
                S_SCAN: begin
                    if (scan_issue) begin
                        r_cnt   <= r_cnt + CNT_W'(1);
                        r_sv    <= 1'b1;
                        r_slast <= (r_col_c == COL_AW'(TEXT_COLS - 1));
                        r_srow  <= r_row_c;
                        if (r_col_c == COL_AW'(TEXT_COLS - 1)) begin
                            r_col_c <= '0;
                            r_row_c <= r_row_c + ROW_AW'(1);
                        end else begin
                            r_col_c <= r_col_c + COL_AW'(1);
                        end
                    end
                    if (r_sv) begin
                        if (r_slast) begin
                            r_acc <= acc_n;
                            r_max <= SCALE_ONE;
                        end else begin
                            r_max <= m_cur;
                        end
                    end
                    if (scan_end) begin
                        r_pos_valid <= 1'b1;
                    end
                end
                S_DONE: begin
                    r_cnt <= '0;
                end
                default: begin
                    r_cnt <= '0;
                end
            endcase
        end
    end

    tcce_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELLS)
    ) u_cell_ram (
        .i_clk  (i_clk),
        .i_we   (c_we),
        .i_waddr(c_waddr),
        .i_wdata(c_wdata),
        .i_raddr(c_raddr),
        .o_rdata(c_rdata)
    );

    tcce_ram #(
        .WIDTH(POS_W),
        .DEPTH(TEXT_ROWS)
    ) u_pos_ram (
        .i_clk  (i_clk),
        .i_we   (p_we),
        .i_waddr(p_waddr),
        .i_wdata(p_wdata),
        .i_raddr(r_cur_row),
        .o_rdata(p_rdata)
    );

`ifndef NO_ASSERTIONS
    a_cursor_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cur_row} < (ROW_AW+1)'(TEXT_ROWS))
        else $error("cursor row beyond the grid");

    a_cursor_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_col != '0)
        else $error("cursor column at zero");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_EXEC))
        else $error("accepted item not executed");

    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_scrolled) |-> (o_cursor_row_out == OROW_W'(TEXT_ROWS - 1)))
        else $error("scroll left the cursor off the last row");
`endif

endmodule

/* tb/text_console_cell_engine_checker.sv */
// Result checker for the text console cell engine: tracks configuration writes and accepted
// characters, keeps its own cursor, scale grid and row positions, and compares every result.
// Depends on tcce_pkg for widths, grid size and character codes.
module text_console_cell_engine_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic [tcce_pkg::CHAR_W-1:0]    i_char_code,
    input  logic                           i_cfg_we,
    input  logic [tcce_pkg::SCALE_W-1:0]   i_cfg_wdata,
    input  logic                           i_done,
    input  logic                           i_draw_valid,
    input  logic [tcce_pkg::OROW_W-1:0]    i_cell_row,
    input  logic [tcce_pkg::OCOL_W-1:0]    i_cell_col,
    input  logic [tcce_pkg::CHAR_W-1:0]    i_glyph_code,
    input  logic [tcce_pkg::SCALE_W-1:0]   i_glyph_scale,
    input  logic [tcce_pkg::PIX_W-1:0]     i_pixel_x,
    input  logic [tcce_pkg::PIX_W-1:0]     i_pixel_y,
    input  logic                           i_scrolled,
    input  logic [tcce_pkg::OROW_W-1:0]    i_cursor_row,
    input  logic [tcce_pkg::OCURCOL_W-1:0] i_cursor_col,
    output int                             o_pending,
    output int                             o_fail_count,
    output int                             o_result_count,
    output int                             o_scroll_count
);
    import tcce_pkg::*;

    typedef struct packed {
        logic                 draw_valid;
        logic [OROW_W-1:0]    cell_row;
        logic [OCOL_W-1:0]    cell_col;
        logic [CHAR_W-1:0]    glyph_code;
        logic [SCALE_W-1:0]   glyph_scale;
        logic [PIX_W-1:0]     pixel_x;
        logic [PIX_W-1:0]     pixel_y;
        logic                 scrolled;
        logic [OROW_W-1:0]    cursor_row;
        logic [OCURCOL_W-1:0] cursor_col;
    } t_console_result;

    // Glyph codes never reach an output, so only the scale of each cell is mirrored.
    logic [SCALE_W-1:0] cell_scale [TEXT_ROWS][TEXT_COLS];
    logic [POS_W-1:0]   row_top [TEXT_ROWS];
    logic [SCALE_W-1:0] scale_reg;
    int unsigned        cur_row;
    int unsigned        cur_col;

    t_console_result queued_results [$];
    int fails;
    int results_seen;
    int scrolls_seen;

    function automatic void clear_console();
        for (int r = 0; r < TEXT_ROWS; r++) begin
            for (int c = 0; c < TEXT_COLS; c++) begin
                cell_scale[r][c] = SCALE_ONE;
            end
            row_top[r] = '0;
        end
        cur_row   = 0;
        cur_col   = 1;
        scale_reg = SCALE_ONE;
    endfunction

    // Each row starts below the previous one by 16 times its tallest glyph; a zero
    // scale still counts as one for the height.
    function automatic void restack_rows();
        logic [POS_W-1:0] acc;
        int unsigned      tallest;
        acc        = '0;
        row_top[0] = '0;
        for (int r = 0; r + 1 < TEXT_ROWS; r++) begin
            tallest = 1;
            for (int c = 0; c < TEXT_COLS; c++) begin
                if (cell_scale[r][c] > tallest) begin
                    tallest = cell_scale[r][c];
                end
            end
            acc = acc + POS_W'(tallest << ROW_HEIGHT_SH);
            row_top[r + 1] = acc;
        end
    endfunction

    function automatic void scroll_up();
        for (int r = 1; r < TEXT_ROWS; r++) begin
            cell_scale[r - 1] = cell_scale[r];
        end
        for (int c = 0; c < TEXT_COLS; c++) begin
            cell_scale[TEXT_ROWS - 1][c] = SCALE_ONE;
        end
        restack_rows();
    endfunction

    function automatic t_console_result apply_char(logic [CHAR_W-1:0] ch);
        t_console_result res;
        res = '0;
        if (ch == CH_NEWLINE) begin
            cur_col = 1;
            cur_row++;
            restack_rows();
        end else if (ch == CH_RETURN) begin
            cur_col = 1;
        end else begin
            if (cur_col < TEXT_COLS && cur_row < TEXT_ROWS) begin
                cell_scale[cur_row][cur_col] = scale_reg;
                res.draw_valid  = 1'b1;
                res.cell_row    = OROW_W'(cur_row);
                res.cell_col    = OCOL_W'(cur_col);
                res.glyph_code  = ch;
                res.glyph_scale = scale_reg;
                res.pixel_x     = PIX_W'((cur_col << GLYPH_W_SH) * scale_reg);
                // The row position is taken as cached, even if it is out of date.
                res.pixel_y     = PIX_W'(row_top[cur_row]);
            end
            cur_col++;
            if (cur_col >= TEXT_COLS) begin
                cur_col = 1;
                cur_row++;
                restack_rows();
            end
        end
        if (cur_row >= TEXT_ROWS) begin
            scroll_up();
            cur_row      = TEXT_ROWS - 1;
            res.scrolled = 1'b1;
        end
        res.cursor_row = OROW_W'(cur_row);
        res.cursor_col = OCURCOL_W'(cur_col);
        return res;
    endfunction

    function automatic int field_bad(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_console_result due;
        if (!i_rst_n) begin
            clear_console();
            queued_results.delete();
        end else begin
            if (i_cfg_we) begin
                scale_reg = i_cfg_wdata;
            end
            if (i_done) begin
                results_seen++;
                if (queued_results.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, %s %0d,%0d",
                             $time, "actual cursor", i_cursor_row, i_cursor_col);
                    fails++;
                end else begin
                    due = queued_results.pop_front();
                    if (due.scrolled) begin
                        scrolls_seen++;
                    end
                    fails += field_bad("draw_valid", due.draw_valid, i_draw_valid);
                    fails += field_bad("cell_row", due.cell_row, i_cell_row);
                    fails += field_bad("cell_col", due.cell_col, i_cell_col);
                    fails += field_bad("glyph_code", due.glyph_code, i_glyph_code);
                    fails += field_bad("glyph_scale", due.glyph_scale, i_glyph_scale);
                    fails += field_bad("pixel_x", due.pixel_x, i_pixel_x);
                    fails += field_bad("pixel_y", due.pixel_y, i_pixel_y);
                    fails += field_bad("scrolled", due.scrolled, i_scrolled);
                    fails += field_bad("cursor_row", due.cursor_row, i_cursor_row);
                    fails += field_bad("cursor_col", due.cursor_col, i_cursor_col);
                end
            end
            if (i_start && !i_busy) begin
                queued_results.push_back(apply_char(i_char_code));
            end
        end
        o_pending      <= queued_results.size();
        o_fail_count   <= fails;
        o_result_count <= results_seen;
        o_scroll_count <= scrolls_seen;
    end

endmodule

/* tb/text_console_cell_engine_tb.sv */
// Testbench top for the text console cell engine: clock, reset, character and scale stimulus,
// a stall watchdog and the verdict. Checking is done by text_console_cell_engine_checker.
// Depends on tcce_pkg, the engine RTL and the checker.
module text_console_cell_engine_tb;
    import tcce_pkg::*;

    // A scroll costs about two grid passes; the clearing pass after reset is one.
    // The limit leaves several times that.
    localparam int STALL_LIMIT = 60000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic [CHAR_W-1:0]    i_char_code = '0;
    logic                 i_cfg_we    = 1'b0;
    logic [SCALE_W-1:0]   i_cfg_wdata = '0;

    logic                 busy;
    logic                 o_done;
    logic                 o_draw_valid;
    logic [OROW_W-1:0]    o_cell_row;
    logic [OCOL_W-1:0]    o_cell_col;
    logic [CHAR_W-1:0]    o_glyph_code;
    logic [SCALE_W-1:0]   o_glyph_scale;
    logic [PIX_W-1:0]     o_pixel_x;
    logic [PIX_W-1:0]     o_pixel_y;
    logic                 o_scrolled;
    logic [OROW_W-1:0]    o_cursor_row_out;
    logic [OCURCOL_W-1:0] o_cursor_col_out;

    int pending;
    int fail_count;
    int result_count;
    int scroll_count;
    int items_sent   = 0;
    int newlines     = 0;
    int quiet_cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    text_console_cell_engine dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_char_code      (i_char_code),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_done           (o_done),
        .o_draw_valid     (o_draw_valid),
        .o_cell_row       (o_cell_row),
        .o_cell_col       (o_cell_col),
        .o_glyph_code     (o_glyph_code),
        .o_glyph_scale    (o_glyph_scale),
        .o_pixel_x        (o_pixel_x),
        .o_pixel_y        (o_pixel_y),
        .o_scrolled       (o_scrolled),
        .o_cursor_row_out (o_cursor_row_out),
        .o_cursor_col_out (o_cursor_col_out)
    );

    text_console_cell_engine_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_char_code    (i_char_code),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_done         (o_done),
        .i_draw_valid   (o_draw_valid),
        .i_cell_row     (o_cell_row),
        .i_cell_col     (o_cell_col),
        .i_glyph_code   (o_glyph_code),
        .i_glyph_scale  (o_glyph_scale),
        .i_pixel_x      (o_pixel_x),
        .i_pixel_y      (o_pixel_y),
        .i_scrolled     (o_scrolled),
        .i_cursor_row   (o_cursor_row_out),
        .i_cursor_col   (o_cursor_col_out),
        .o_pending      (pending),
        .o_fail_count   (fail_count),
        .o_result_count (result_count),
        .o_scroll_count (scroll_count)
    );

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("text_console_cell_engine test failed");
            $finish;
        end
    end

    // Returns on the edge that takes the item, with start still high so that a
    // following item can go straight out.
    task automatic send_char(input logic [CHAR_W-1:0] ch, input bit may_idle);
        int gap;
        gap = 0;
        if (may_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_char_code <= ch;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        items_sent++;
        if (ch == CH_NEWLINE) begin
            newlines++;
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [CHAR_W-1:0] ch;
        int pick;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes, codes next to the control codes, and scale 1, 7 and 0.
        send_char(8'd65, 1);
        send_char(8'd0, 1);
        send_char(8'd255, 1);
        send_char(CH_RETURN, 1);
        send_char(8'd66, 1);
        send_char(8'd12, 1);
        send_char(8'd14, 1);
        write_scale(3'd7);
        send_char(8'd127, 1);
        send_char(8'd128, 1);
        send_char(CH_NEWLINE, 1);
        send_char(8'd120, 1);
        send_char(8'd9, 1);
        send_char(8'd11, 1);
        write_scale(3'd0);
        send_char(8'd48, 1);
        send_char(CH_NEWLINE, 1);
        send_char(8'd200, 1);
        send_char(CH_RETURN, 1);
        send_char(CH_NEWLINE, 1);
        send_char(CH_NEWLINE, 1);

        // Random: mostly newlines so that the cursor reaches the bottom and scrolls.
        for (int p = 0; p < 5; p++) begin
            write_scale(p == 0 ? 3'd1 : p == 1 ? 3'd7 : SCALE_W'($urandom_range(0, 7)));
            for (int k = 0; k < 20; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    ch = CH_NEWLINE;
                end else if (pick < 63) begin
                    ch = CH_RETURN;
                end else begin
                    ch = CHAR_W'($urandom_range(0, 255));
                end
                send_char(ch, 1);
                if (p == 2 && k == 9) begin
                    drain();
                end
            end
        end

        // Make sure at least one newline scroll has happened.
        while (newlines < TEXT_ROWS) begin
            send_char(CH_NEWLINE, 1);
        end

        // Last part, back to back: a full line at scale 7 on the bottom row, which
        // wraps and scrolls, then a few glyphs below it and a final newline.
        write_scale(3'd7);
        send_char(CH_RETURN, 0);
        for (int k = 0; k < TEXT_COLS + 2; k++) begin
            send_char(CHAR_W'($urandom_range(32, 126)), 0);
        end
        send_char(CH_NEWLINE, 0);

        drain();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d characters, %0d of them newlines, across eight scale writes.",
                 items_sent, newlines);
        $display("%0d results were compared and %0d of them reported a scroll.",
                 result_count, scroll_count);
        if (fail_count == 0) begin
            $display("text_console_cell_engine test passed");
        end else begin
            $display("text_console_cell_engine test failed");
        end
        $finish;
    end

endmodule
